FILE: design/bmorph_pkg.sv
// Package for the binary morphology block: state encoding, register map,
// field widths and register reset values. No dependencies.
package bmorph_pkg;

  localparam int unsigned CoordW   = 6;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned MaskBits = 25;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 4;

  localparam logic [SizeW-1:0]    WidthRst = 7'd64;
  localparam logic [SizeW-1:0]    HeightRst = 7'd64;
  localparam logic                ModeRst  = 1'b0;
  localparam logic [MaskBits-1:0] MaskRst  = 25'd4096;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_MASK   = 2'd3
  } bmorph_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } bmorph_op_t;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } bmorph_mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_HOLD
  } bmorph_state_t;

endpackage

FILE: design/bmorph_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependencies.
module bmorph_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/binary_morphology_dilate_erode.sv
// Top level of the binary morphology engine (dilation / erosion).
// Depends on bmorph_pkg and bmorph_ram.
//
// Usage: the block keeps a one-bit image of MAX_WIDTH x MAX_HEIGHT pixels in
// a single-port RAM. Each input item (valid/ready) either writes one pixel
// (op 0) or asks for the dilation or erosion result at one pixel (op 1).
// Every item gives exactly one result item (valid/ready) with result_pixel
// and coord_error; an out-of-range coordinate gives coord_error 1, result 0,
// and a write with it is dropped.
// Sizes, mode and element mask sit on the APB port; the user is to write
// them only while the block is idle, as the block itself does not enforce it.
// Flow: a write or an erroring item passes through ST_HOLD; its result moves
// to the output register once the output slot is free, and the block then
// returns to idle for the next item. A query walks the (2*RADIUS+1)^2 window
// positions one per cycle through the single RAM port, then goes through
// ST_LAST and ST_HOLD to the output register. The next item is taken once
// the result has moved to the output register, so a stalled receiver lets
// one further item be taken, which then waits in ST_HOLD.
// Reset: a clearing pass writes all MAX_WIDTH*MAX_HEIGHT addresses (4096 by
// default) to zero the image; no item is accepted during it, config writes are.
module binary_morphology_dilate_erode #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned RADIUS     = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [bmorph_pkg::CoordW-1:0]     in_column,
  input  logic [bmorph_pkg::CoordW-1:0]     in_row,
  input  logic                              in_pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_pixel,
  output logic                              out_coord_error,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmorph_pkg::AddrW-1:0]      paddr,
  input  logic [bmorph_pkg::DataW-1:0]      pwdata,
  output logic [bmorph_pkg::DataW-1:0]      prdata,
  output logic                              pready
);
  import bmorph_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WS    = 2 * RADIUS + 1;
  localparam int unsigned NPos  = WS * WS;
  localparam int unsigned KXW   = $clog2(WS);
  localparam int unsigned KW    = $clog2(NPos);
  localparam int unsigned SW    = 9;

  // configuration
  logic [SizeW-1:0]    image_width_r, image_height_r;
  logic                mode_r;
  logic [MaskBits-1:0] element_mask_r;
  logic                cfg_we;
  bmorph_reg_t         cfg_idx;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign cfg_idx = bmorph_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WidthRst;
      image_height_r <= HeightRst;
      mode_r         <= ModeRst;
      element_mask_r <= MaskRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  image_width_r  <= pwdata[SizeW-1:0];
        REG_HEIGHT: image_height_r <= pwdata[SizeW-1:0];
        REG_MODE:   mode_r         <= pwdata[0];
        REG_MASK:   element_mask_r <= pwdata[MaskBits-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = DataW'(image_width_r);
      REG_HEIGHT: prdata = DataW'(image_height_r);
      REG_MODE:   prdata = DataW'(mode_r);
      REG_MASK:   prdata = DataW'(element_mask_r);
      default:    prdata = '0;
    endcase
  end

  // effective sizes, clamped to the store
  logic [SizeW-1:0] w_eff, h_eff;
  assign w_eff = (32'(image_width_r) > MAX_WIDTH) ? SizeW'(MAX_WIDTH) : image_width_r;
  assign h_eff = (32'(image_height_r) > MAX_HEIGHT) ? SizeW'(MAX_HEIGHT) : image_height_r;

  // sequencer state
  bmorph_state_t         state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  op_r, op_nxt;
  logic [CoordW-1:0]     col_r, col_nxt, row_r, row_nxt;
  logic                  err_r, err_nxt;
  logic                  acc_r, acc_nxt;
  logic [KXW-1:0]        kx_r, kx_nxt, ky_r, ky_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_result_pixel_r, out_result_pixel_nxt;
  logic                  out_coord_error_r, out_coord_error_nxt;

  logic                  accept, in_err, clr_last, scan_last, slot_free;
  logic                  ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]         ram_addr, in_addr, win_addr;
  logic [SW-1:0]         off_x, off_y, sx, sy;
  logic                  src_in_image, present;
  logic [MaskBits-1:0]   mask_shift;

  assign accept    = in_valid & in_ready;
  assign in_err    = (SizeW'(in_column) >= w_eff) || (SizeW'(in_row) >= h_eff);
  assign clr_last  = (clr_addr_r == AW'(Depth - 1));
  assign scan_last = (k_r == KW'(NPos - 1));
  assign slot_free = !out_valid_r || out_ready;
  assign in_addr   = AW'(32'(in_row) * MAX_WIDTH + 32'(in_column));

  // window position for the current step
  assign off_x = SW'(kx_r) - SW'(RADIUS);
  assign off_y = SW'(ky_r) - SW'(RADIUS);
  assign sx = (mode_r == MODE_ERODE) ? SW'(col_r) + off_x : SW'(col_r) - off_x;
  assign sy = (mode_r == MODE_ERODE) ? SW'(row_r) + off_y : SW'(row_r) - off_y;
  assign src_in_image = !sx[SW-1] && !sy[SW-1] && (sx < SW'(w_eff)) && (sy < SW'(h_eff));
  assign mask_shift = element_mask_r >> k_r;
  assign present = mask_shift[0];
  assign win_addr = AW'(32'(sy) * MAX_WIDTH + 32'(sx));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == OP_QUERY && !in_err) ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: if (scan_last) state_nxt = ST_LAST;
      ST_LAST: state_nxt = ST_HOLD;
      ST_HOLD: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready             = (state_r == ST_IDLE);
    ram_we               = 1'b0;
    ram_wdata            = 1'b0;
    ram_addr             = win_addr;
    clr_addr_nxt         = clr_addr_r;
    op_nxt               = op_r;
    col_nxt              = col_r;
    row_nxt              = row_r;
    err_nxt              = err_r;
    acc_nxt              = acc_r;
    kx_nxt               = kx_r;
    ky_nxt               = ky_r;
    k_nxt                = k_r;
    rd_pend_nxt          = 1'b0;
    out_valid_nxt        = out_valid_r & ~out_ready;
    out_result_pixel_nxt = out_result_pixel_r;
    out_coord_error_nxt  = out_coord_error_r;

    if (rd_pend_r) begin
      acc_nxt = (mode_r == MODE_ERODE) ? (acc_r & ram_rdata) : (acc_r | ram_rdata);
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        ram_addr = in_addr;
        if (accept) begin
          op_nxt  = in_op;
          col_nxt = in_column;
          row_nxt = in_row;
          err_nxt = in_err;
          acc_nxt = mode_r;
          kx_nxt  = '0;
          ky_nxt  = '0;
          k_nxt   = '0;
          if (in_op == OP_WRITE && !in_err) begin
            ram_we    = 1'b1;
            ram_wdata = in_pixel;
          end
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = present && src_in_image;
        k_nxt = k_r + KW'(1);
        if (kx_r == KXW'(WS - 1)) begin
          kx_nxt = '0;
          ky_nxt = ky_r + KXW'(1);
        end else begin
          kx_nxt = kx_r + KXW'(1);
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_result_pixel_nxt = (op_r == OP_QUERY) && !err_r && acc_r;
          out_coord_error_nxt  = err_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r               <= op_nxt;
    col_r              <= col_nxt;
    row_r              <= row_nxt;
    err_r              <= err_nxt;
    acc_r              <= acc_nxt;
    kx_r               <= kx_nxt;
    ky_r               <= ky_nxt;
    k_r                <= k_nxt;
    out_result_pixel_r <= out_result_pixel_nxt;
    out_coord_error_r  <= out_coord_error_nxt;
  end

  bmorph_ram #(
    .WIDTH(1),
    .DEPTH(Depth)
  ) u_image_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_result_pixel = out_result_pixel_r;
  assign out_coord_error  = out_coord_error_r;

  a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("image store written outside clear or idle");

  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_QUERY && !in_err) |=> (state_r == ST_SCAN))
    else $error("in-range query did not start a window scan");

  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_HOLD))
    else $error("result item raised outside hold state");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_coord_error_r) |-> !out_result_pixel_r)
    else $error("coordinate error item carries a set result");

  a_no_read_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN || state_r == ST_LAST))
    else $error("window read outstanding outside a scan");

endmodule

FILE: verif/bmorph_checker.sv
// Result checker for the binary morphology block: follows register writes and
// accepted items, predicts each result from its own image copy and compares.
// Depends on bmorph_pkg.
module bmorph_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_op,
  input  logic [bmorph_pkg::CoordW-1:0]     in_column,
  input  logic [bmorph_pkg::CoordW-1:0]     in_row,
  input  logic                              in_pixel,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_result_pixel,
  input  logic                              out_coord_error,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [bmorph_pkg::AddrW-1:0]      paddr,
  input  logic [bmorph_pkg::DataW-1:0]      pwdata,
  output int unsigned                       error_count,
  output int unsigned                       pending_count
);
  import bmorph_pkg::*;

  localparam int MaxSide = 64;
  localparam int Reach   = 2;
  localparam int Span    = 2 * Reach + 1;

  typedef struct packed {
    logic result_pixel;
    logic coord_error;
  } pixel_result_t;

  logic                image [0:MaxSide*MaxSide-1];
  logic [SizeW-1:0]    width_r;
  logic [SizeW-1:0]    height_r;
  bmorph_mode_t        mode_r;
  logic [MaskBits-1:0] element_r;
  pixel_result_t       awaited_results[$];
  int unsigned         bad_results;

  function automatic int size_in_use(input logic [SizeW-1:0] v);
    return (v > SizeW'(MaxSide)) ? MaxSide : int'(v);
  endfunction

  function automatic logic morph_at(input int c, input int r);
    int  w, h, sc, sr;
    logic acc;
    w   = size_in_use(width_r);
    h   = size_in_use(height_r);
    acc = (mode_r == MODE_ERODE);
    for (int dy = -Reach; dy <= Reach; dy++) begin
      for (int dx = -Reach; dx <= Reach; dx++) begin
        if (element_r[(dy + Reach) * Span + dx + Reach]) begin
          if (mode_r == MODE_ERODE) begin
            sc = c + dx;
            sr = r + dy;
          end else begin
            sc = c - dx;
            sr = r - dy;
          end
          // window positions off the image are skipped in both modes
          if (sc >= 0 && sr >= 0 && sc < w && sr < h) begin
            if (mode_r == MODE_ERODE && !image[sr*MaxSide+sc]) acc = 1'b0;
            if (mode_r == MODE_DILATE && image[sr*MaxSide+sc]) acc = 1'b1;
          end
        end
      end
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    int c, r;
    if (!rst_n) begin
      foreach (image[i]) image[i] = 1'b0;
      width_r   = WidthRst;
      height_r  = HeightRst;
      mode_r    = bmorph_mode_t'(ModeRst);
      element_r = MaskRst;
      awaited_results.delete();
      bad_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          bad_results++;
          $display("%0t: unexpected result item: pixel %0b, error %0b", $time,
                   out_result_pixel, out_coord_error);
        end else begin
          want = awaited_results.pop_front();
          if (out_result_pixel !== want.result_pixel) begin
            bad_results++;
            $display("%0t: result_pixel mismatch: expected %0b, actual %0b", $time,
                     want.result_pixel, out_result_pixel);
          end
          if (out_coord_error !== want.coord_error) begin
            bad_results++;
            $display("%0t: coord_error mismatch: expected %0b, actual %0b", $time,
                     want.coord_error, out_coord_error);
          end
        end
      end
      if (in_valid && in_ready) begin
        c    = int'(in_column);
        r    = int'(in_row);
        want = '0;
        if (c >= size_in_use(width_r) || r >= size_in_use(height_r))
          want.coord_error = 1'b1;
        else if (in_op == OP_WRITE)
          image[r*MaxSide+c] = in_pixel;
        else
          want.result_pixel = morph_at(c, r);
        awaited_results.push_back(want);
      end
      if (psel && penable && pwrite && pready) begin
        case (bmorph_reg_t'(paddr[AddrW-1:2]))
          REG_WIDTH:  width_r   = pwdata[SizeW-1:0];
          REG_HEIGHT: height_r  = pwdata[SizeW-1:0];
          REG_MODE:   mode_r    = bmorph_mode_t'(pwdata[0]);
          REG_MASK:   element_r = pwdata[MaskBits-1:0];
          default: ;
        endcase
      end
    end
    error_count   <= bad_results;
    pending_count <= awaited_results.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the binary morphology testbench: clock, reset, register setup, item
// traffic with random idling on both channels, and the final verdict.
// Depends on bmorph_pkg, binary_morphology_dilate_erode and bmorph_checker.
module testbench;
  import bmorph_pkg::*;

  localparam int unsigned RandomItems  = 1150;
  localparam int unsigned CalmTail     = 150;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 40;
  localparam logic [MaskBits-1:0] FullMask  = '1;
  localparam logic [MaskBits-1:0] CrossMask = 25'h0427C84;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_op      = 1'b0;
  logic [CoordW-1:0]   in_column  = '0;
  logic [CoordW-1:0]   in_row     = '0;
  logic                in_pixel   = 1'b0;
  logic                out_ready  = 1'b0;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [AddrW-1:0]    paddr      = '0;
  logic [DataW-1:0]    pwdata     = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_result_pixel;
  logic                out_coord_error;
  logic [DataW-1:0]    prdata;
  logic                pready;
  int unsigned         error_count;
  int unsigned         pending_count;
  bit                  hold_output = 1'b0;
  bit                  steady      = 1'b0;
  int unsigned         sent        = 0;

  always #4 clk = ~clk;

  binary_morphology_dilate_erode DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_pixel (out_result_pixel),
    .out_coord_error  (out_coord_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  bmorph_checker morph_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_pixel (out_result_pixel),
    .out_coord_error  (out_coord_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .error_count      (error_count),
    .pending_count    (pending_count)
  );

  task automatic push_item(input bmorph_op_t op, input int col, input int row,
                           input logic pix);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_column <= col[CoordW-1:0];
    in_row    <= row[CoordW-1:0];
    in_pixel  <= pix;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic reg_write(input bmorph_reg_t idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h,
                            input bmorph_mode_t md, input logic [MaskBits-1:0] elem);
    reg_write(REG_WIDTH, DataW'(w));
    reg_write(REG_HEIGHT, DataW'(h));
    reg_write(REG_MODE, DataW'(md));
    reg_write(REG_MASK, DataW'(elem));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 10))
      0:       return 7'd64;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd1;
      3:       return 7'd0;
      default: return 7'($urandom_range(2, 9));
    endcase
  endfunction

  function automatic int pick_coord(input int n);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic run_phase(input int unsigned idx);
    logic [SizeW-1:0]    w_reg, h_reg;
    logic [MaskBits-1:0] elem;
    bmorph_mode_t        md;
    int                  w, h, n, density, kind;
    if (idx == 0) begin
      w_reg = 7'd64;
      h_reg = 7'd64;
    end else if (idx == 1) begin
      w_reg = 7'd127;
      h_reg = 7'($urandom_range(65, 127));
    end else begin
      w_reg = pick_size();
      h_reg = pick_size();
    end
    md = bmorph_mode_t'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0:       elem = FullMask;
      1:       elem = MaskRst;
      2:       elem = CrossMask;
      3:       elem = '0;
      4:       elem = 25'($urandom) & 25'($urandom);
      default: elem = 25'($urandom);
    endcase
    wait_drained();
    set_config(w_reg, h_reg, md, elem);
    w       = (w_reg > 7'd64) ? 64 : int'(w_reg);
    h       = (h_reg > 7'd64) ? 64 : int'(h_reg);
    density = $urandom_range(1, 3);
    if (idx == 2) hold_output = 1'b1;
    // paint the image first so that queries see real content
    if (w * h <= 64) begin
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          push_item(OP_WRITE, c, r, $urandom_range(0, 3) < density);
    end else begin
      repeat (40) push_item(OP_WRITE, pick_coord(w), pick_coord(h),
                            $urandom_range(0, 3) < density);
    end
    n = (w == 0 || h == 0) ? 12 : $urandom_range(60, 110);
    for (int k = 0; k < n && sent < RandomItems; k++) begin
      if (idx == 4 && k == n / 2) wait_drained();
      if (sent + CalmTail >= RandomItems) steady = 1'b1;
      kind = $urandom_range(0, 19);
      if (w == 0 || h == 0 || kind < 3)
        push_item(bmorph_op_t'($urandom_range(0, 1)), $urandom_range(0, 63),
                  $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      else if (kind < 8)
        push_item(OP_WRITE, pick_coord(w), pick_coord(h), $urandom_range(0, 3) < density);
      else
        push_item(OP_QUERY, pick_coord(w), pick_coord(h), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    wait (rst_n);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_output = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned idx;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: full size, dilation, centre offset only
    push_item(OP_WRITE, 0, 0, 1'b1);
    push_item(OP_WRITE, 63, 63, 1'b1);
    push_item(OP_WRITE, 63, 0, 1'b1);
    push_item(OP_QUERY, 0, 0, 1'b0);
    push_item(OP_QUERY, 63, 63, 1'b0);
    push_item(OP_QUERY, 1, 1, 1'b1);
    push_item(OP_WRITE, 63, 63, 1'b0);
    push_item(OP_QUERY, 63, 63, 1'b1);

    wait_drained();
    set_config(7'd3, 7'd2, MODE_DILATE, FullMask);
    push_item(OP_QUERY, 2, 1, 1'b0);
    push_item(OP_QUERY, 3, 0, 1'b0);
    push_item(OP_WRITE, 5, 5, 1'b1);
    push_item(OP_QUERY, 0, 1, 1'b0);

    wait_drained();
    set_config(7'd3, 7'd2, MODE_ERODE, FullMask);
    push_item(OP_QUERY, 1, 0, 1'b0);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        push_item(OP_WRITE, c, r, 1'b1);
    push_item(OP_QUERY, 1, 1, 1'b0);

    // empty element
    wait_drained();
    set_config(7'd3, 7'd2, MODE_ERODE, '0);
    push_item(OP_QUERY, 0, 0, 1'b0);
    wait_drained();
    set_config(7'd3, 7'd2, MODE_DILATE, '0);
    push_item(OP_QUERY, 0, 0, 1'b0);

    // zero width: everything errors
    wait_drained();
    set_config(7'd0, 7'd64, MODE_DILATE, MaskRst);
    push_item(OP_WRITE, 0, 0, 1'b1);
    push_item(OP_QUERY, 0, 0, 1'b0);

    // oversize registers clamp to the full image
    wait_drained();
    set_config(7'd127, 7'd127, MODE_DILATE, FullMask);
    push_item(OP_QUERY, 63, 63, 1'b0);
    push_item(OP_QUERY, 63, 5, 1'b1);

    sent = 0;
    idx  = 0;
    while (sent < RandomItems) begin
      run_phase(idx);
      idx++;
    end

    steady = 1'b1;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
